### rtl/x87pr_pkg.sv
// Shared types and constants for the x87 precision rounding block.
// No dependencies; used by x87pr_round and x87_precision_rounding.
package x87pr_pkg;

  localparam int SigW = 64;
  localparam int ExpW = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam int TdataW = 88;

  // Rounding mode register codes.
  typedef enum logic [1:0] {
    RND_NEAREST = 2'd0,
    RND_DOWN    = 2'd1,
    RND_UP      = 2'd2,
    RND_CHOP    = 2'd3
  } x87pr_rmode_t;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ROUNDING_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRECISION     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OVF_LIMIT     = 2'd2;

  // Precision select codes.
  localparam logic PREC_24 = 1'b0;
  localparam logic PREC_53 = 1'b1;

  // Discarded-bit masks, half point and unit in the last kept place.
  localparam logic [SigW-1:0] MASK_53 = 64'h0000_0000_0000_07ff;
  localparam logic [SigW-1:0] HALF_53 = 64'h0000_0000_0000_0400;
  localparam logic [SigW-1:0] UNIT_53 = 64'h0000_0000_0000_0800;
  localparam logic [SigW-1:0] MASK_24 = 64'h0000_00ff_ffff_ffff;
  localparam logic [SigW-1:0] HALF_24 = 64'h0000_0080_0000_0000;
  localparam logic [SigW-1:0] UNIT_24 = 64'h0000_0100_0000_0000;
  localparam logic [SigW-1:0] SIG_TOP = 64'h8000_0000_0000_0000;

  localparam logic signed [ExpW-1:0] EXP_MAX = 16'sh7fff;
  localparam logic signed [ExpW-1:0] OVF_LIMIT_RESET = 16'sh4000;

  typedef struct packed {
    logic                   value_valid;
    logic                   sign;
    logic signed [ExpW-1:0] exponent;
    logic [SigW-1:0]        significand;
  } x87pr_item_t;

  typedef struct packed {
    logic                   sign;
    logic signed [ExpW-1:0] exponent;
    logic [SigW-1:0]        significand;
    logic                   overflow;
  } x87pr_result_t;

endpackage

### rtl/x87_precision_rounding.sv
// Top level: configuration registers, input register, rounding logic, result register.
// Depends on x87pr_pkg and x87pr_round.
//
// Rounds an x87 extended significand to 24 or 53 bits under the configured rounding
// mode. One item is accepted per clock cycle while the output side takes results.
// Each item is captured in the input register, and the rounding logic with its 64-bit
// carry add sits between the input register and the result register, from which the
// result is presented on the output. Either stage holds its item while the next side
// stalls, so the block keeps taking items as long as the output side takes results.
// Overflow is reported in m_axis_tuser only; no infinity or maximum substitution is
// done. Configuration is to be written by the user only while idle; the block itself
// does not enforce this.
module x87_precision_rounding
  import x87pr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TdataW-1:0]   s_axis_tdata,  // sign_in, exponent_in[15:0], significand_in[63:0]
  input  logic                s_axis_tuser,  // value_valid

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TdataW-1:0]   m_axis_tdata,  // sign_out, exponent_out[15:0], significand_out[63:0]
  output logic                m_axis_tuser   // overflow
);

  x87pr_rmode_t           rounding_mode;
  logic                   precision_select;
  logic signed [ExpW-1:0] overflow_limit;

  logic          in_valid;
  x87pr_item_t   in_item;
  logic          out_valid;
  x87pr_result_t out_res;
  x87pr_result_t rnd_res;
  logic          out_free;
  logic          advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      rounding_mode    <= RND_NEAREST;
      precision_select <= PREC_53;
      overflow_limit   <= OVF_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROUNDING_MODE: rounding_mode    <= x87pr_rmode_t'(cfg_data[1:0]);
        CFG_PRECISION:     precision_select <= cfg_data[0];
        CFG_OVF_LIMIT:     overflow_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free      = ~out_valid | m_axis_tready;
  assign advance       = in_valid & out_free;
  assign s_axis_tready = ~in_valid | out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.value_valid <= s_axis_tuser;
      in_item.sign        <= s_axis_tdata[0];
      in_item.exponent    <= s_axis_tdata[ExpW:1];
      in_item.significand <= s_axis_tdata[ExpW+SigW:ExpW+1];
    end
  end

  x87pr_round u_round (
    .rounding_mode    (rounding_mode),
    .precision_select (precision_select),
    .overflow_limit   (overflow_limit),
    .item             (in_item),
    .result           (rnd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= rnd_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(TdataW-SigW-ExpW-1){1'b0}}, out_res.significand,
                          out_res.exponent, out_res.sign};
  assign m_axis_tuser  = out_res.overflow;

  // An overflow can only come from a carry, which leaves the top bit alone.
  a_ovf_top: assert property (@(posedge clk) disable iff (rst)
    (in_valid && rnd_res.overflow) |-> (rnd_res.significand == SIG_TOP))
    else $error("overflow without renormalized significand");

  // Items that are not valid numbers pass through unchanged.
  a_passthru: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_item.value_valid) |->
      (rnd_res.significand == in_item.significand && rnd_res.exponent == in_item.exponent
       && !rnd_res.overflow))
    else $error("invalid item altered");

  // A held item in the input register stays there until the result stage frees up.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_free) |=> (in_valid && $stable(in_item)))
    else $error("input stage item lost while stalled");

  // A valid rounded result never keeps bits below the 53-bit boundary.
  a_low_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_item.value_valid) |-> ((rnd_res.significand & MASK_53) == '0))
    else $error("discarded bits not cleared");

  // Reset leaves both stages empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_valid && !out_valid))
    else $error("pipeline not empty after reset");

endmodule

### rtl/x87pr_round.sv
// Combinational significand rounding to 24 or 53 bits with carry handling.
// Depends on x87pr_pkg.
module x87pr_round
  import x87pr_pkg::*;
(
  input  x87pr_rmode_t           rounding_mode,
  input  logic                   precision_select,
  input  logic signed [ExpW-1:0] overflow_limit,
  input  x87pr_item_t            item,
  output x87pr_result_t          result
);

  logic [SigW-1:0]        mask;
  logic [SigW-1:0]        half;
  logic [SigW-1:0]        unit;
  logic                   guard;
  logic                   sticky;
  logic                   lsb;
  logic                   any_rest;
  logic                   inc;
  logic [SigW-1:0]        kept;
  logic [SigW:0]          sum;
  logic signed [ExpW:0]   exp_inc;
  logic signed [ExpW:0]   limit_ext;

  always_comb begin
    mask = (precision_select == PREC_53) ? MASK_53 : MASK_24;
    half = (precision_select == PREC_53) ? HALF_53 : HALF_24;
    unit = (precision_select == PREC_53) ? UNIT_53 : UNIT_24;

    guard    = |(item.significand & half);
    sticky   = |(item.significand & (mask >> 1));
    lsb      = |(item.significand & unit);
    any_rest = guard | sticky;

    case (rounding_mode)
      RND_NEAREST: inc = guard & (sticky | lsb);
      RND_DOWN:    inc = item.sign & any_rest;
      RND_UP:      inc = ~item.sign & any_rest;
      RND_CHOP:    inc = 1'b0;
      default:     inc = 1'b0;
    endcase

    kept      = item.significand & ~mask;
    sum       = {1'b0, kept} + {1'b0, unit};
    exp_inc   = {item.exponent[ExpW-1], item.exponent} + 17'sd1;
    limit_ext = {overflow_limit[ExpW-1], overflow_limit};

    result.sign        = item.sign;
    result.exponent    = item.exponent;
    result.significand = item.significand;
    result.overflow    = 1'b0;

    if (item.value_valid) begin
      if (!inc) begin
        result.significand = kept;
      end else if (sum[SigW]) begin
        // carry out of the significand: renormalize to the top bit
        result.significand = SIG_TOP;
        result.overflow    = (exp_inc >= limit_ext);
        result.exponent    = (item.exponent == EXP_MAX) ? EXP_MAX : exp_inc[ExpW-1:0];
      end else begin
        result.significand = sum[SigW-1:0];
      end
    end
  end

endmodule

### tb/x87_precision_rounding_tb.sv
// Self-checking testbench for x87_precision_rounding: a directed stimulus table, then random
// phases under every rounding mode and precision, with results checked against a local model.
// Depends on x87pr_pkg and the RTL of x87_precision_rounding.
`timescale 1ns / 1ps

module x87_precision_rounding_tb;
  import x87pr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    x87pr_rmode_t           mode;
    logic                   prec;
    logic signed [ExpW-1:0] limit;
    logic                   value_valid;
    logic                   sign;
    logic signed [ExpW-1:0] exponent;
    logic [SigW-1:0]        significand;
    logic                   typed;
    x87pr_result_t          want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TdataW-1:0]   s_axis_tdata = '0;  // sign_in, exponent_in[15:0], significand_in[63:0]
  logic                s_axis_tuser = 1'b0;  // value_valid
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TdataW-1:0]   m_axis_tdata;  // sign_out, exponent_out[15:0], significand_out[63:0]
  logic                m_axis_tuser;  // overflow

  // typed expectation travels alongside the item on the input side
  logic                   item_typed = 1'b0;
  x87pr_result_t          item_want = '0;

  x87pr_rmode_t           cur_mode = RND_NEAREST;
  logic                   cur_prec = PREC_53;
  logic signed [ExpW-1:0] cur_limit = OVF_LIMIT_RESET;

  x87pr_result_t rounded_q[$];
  stim_row_t     stim_table[$];
  int            n_sent = 0;
  int            n_recv = 0;
  int            fails = 0;
  int            quiet_cycles = 0;
  int            ready_hold = 0;
  logic          idle_on = 1'b1;

  x87_precision_rounding dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic x87pr_result_t round_value(input logic v, input logic s,
                                                input logic signed [ExpW-1:0] e,
                                                input logic [SigW-1:0] sig);
    x87pr_result_t          r;
    int                     drop;
    logic [SigW-1:0]        lowm;
    logic [SigW-1:0]        half;
    logic [SigW-1:0]        unit;
    logic [SigW-1:0]        rest;
    logic [SigW:0]          sum;
    logic signed [ExpW:0]   e1;
    logic                   bump;
    r.sign = s;
    r.exponent = e;
    r.significand = sig;
    r.overflow = 1'b0;
    if (v) begin
      drop = (cur_prec == PREC_53) ? 11 : 40;
      unit = 64'd1 << drop;
      half = unit >> 1;
      lowm = unit - 64'd1;
      rest = sig & lowm;
      case (cur_mode)
        RND_NEAREST: bump = (rest > half) || (rest == half && (sig & unit) != 0);
        RND_DOWN:    bump = s && rest != 0;
        RND_UP:      bump = !s && rest != 0;
        default:     bump = 1'b0;
      endcase
      r.significand = sig & ~lowm;
      if (bump) begin
        sum = {1'b0, r.significand} + {1'b0, unit};
        if (sum[SigW]) begin
          // carry out: top bit alone, exponent up, saturating at its max
          r.significand = SIG_TOP;
          e1 = $signed({e[ExpW-1], e}) + 17'sd1;
          r.overflow = e1 >= $signed({cur_limit[ExpW-1], cur_limit});
          r.exponent = (e1 > $signed({1'b0, EXP_MAX})) ? EXP_MAX : e1[ExpW-1:0];
        end else begin
          r.significand = sum[SigW-1:0];
        end
      end
    end
    return r;
  endfunction

  task automatic add_row(input x87pr_rmode_t mode, input logic prec,
                         input logic signed [ExpW-1:0] limit, input logic v, input logic s,
                         input logic signed [ExpW-1:0] e, input logic [SigW-1:0] sig,
                         input logic typed, input logic signed [ExpW-1:0] we,
                         input logic [SigW-1:0] wsig, input logic wovf);
    stim_row_t row;
    row.mode = mode;
    row.prec = prec;
    row.limit = limit;
    row.value_valid = v;
    row.sign = s;
    row.exponent = e;
    row.significand = sig;
    row.typed = typed;
    row.want.sign = s;
    row.want.exponent = we;
    row.want.significand = wsig;
    row.want.overflow = wovf;
    stim_table.push_back(row);
  endtask

  task automatic send_item(input logic v, input logic s, input logic signed [ExpW-1:0] e,
                           input logic [SigW-1:0] sig, input logic typed,
                           input x87pr_result_t want);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, sig, e, s};
    s_axis_tuser <= v;
    item_typed <= typed;
    item_want <= want;
    do @(posedge clk); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic send_random();
    logic [SigW-1:0]        sig;
    logic [SigW-1:0]        lowm;
    logic [SigW-1:0]        half;
    logic signed [ExpW-1:0] e;
    logic [31:0]            r;
    lowm = (cur_prec == PREC_53) ? 64'h7ff : 64'hff_ffff_ffff;
    half = (lowm >> 1) + 64'd1;
    sig = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: sig = ~(sig & 64'h1ff_ffff_ffff);  // near a carry out
      2: sig = (sig & ~lowm) | half;         // exact tie
      3: sig = sig & ~lowm;                  // already exact
      4: sig = (sig & ~lowm) | (half + 64'd1 - 64'($urandom_range(0, 2)));
      default: sig = sig | SIG_TOP;
    endcase
    r = $urandom;
    case ($urandom_range(0, 4))
      0: e = cur_limit - 16'(r[1:0]);
      1: e = EXP_MAX - 16'(r[0]);
      2: e = 16'sh8000;
      default: e = r[ExpW-1:0];
    endcase
    send_item($urandom_range(0, 7) != 0, r[31], e, sig, 1'b0, '0);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (n_recv != n_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input x87pr_rmode_t mode, input logic prec,
                           input logic signed [ExpW-1:0] limit);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROUNDING_MODE;
    cfg_data <= {14'd0, mode};
    @(posedge clk);
    cfg_index <= CFG_PRECISION;
    cfg_data <= {15'd0, prec};
    @(posedge clk);
    cfg_index <= CFG_OVF_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = mode;
    cur_prec = prec;
    cur_limit = limit;
  endtask

  // result side stalls in bursts while idle_on is set
  always @(posedge clk) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    x87pr_result_t got;
    x87pr_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.sign = m_axis_tdata[0];
        got.exponent = m_axis_tdata[16:1];
        got.significand = m_axis_tdata[80:17];
        got.overflow = m_axis_tuser;
        if (rounded_q.size() == 0) begin
          $error("result with no item pending: significand_out %h", got.significand);
          fails++;
        end else begin
          want = rounded_q.pop_front();
          if (got.sign !== want.sign) begin
            $error("sign_out: expected %0d, actual %0d", want.sign, got.sign);
            fails++;
          end
          if (got.exponent !== want.exponent) begin
            $error("exponent_out: expected %0d, actual %0d",
                   $signed(want.exponent), $signed(got.exponent));
            fails++;
          end
          if (got.significand !== want.significand) begin
            $error("significand_out: expected %h, actual %h",
                   want.significand, got.significand);
            fails++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
            fails++;
          end
        end
        n_recv++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (item_typed)
          rounded_q.push_back(item_want);
        else
          rounded_q.push_back(round_value(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[16:1],
                                          s_axis_tdata[80:17]));
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t        row;
    x87pr_rmode_t     mode;
    logic signed [ExpW-1:0] limit;
    // reset settings: nearest, 53 bits, limit 16384
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b0, 1'b1, 16'sh8000, 64'hffff_ffff_ffff_ffff,
            1'b1, 16'sh8000, 64'hffff_ffff_ffff_ffff, 1'b0);
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b1, 1'b0, 16'sh0000, 64'h0,
            1'b1, 16'sh0000, 64'h0, 1'b0);
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b1, 1'b0, 16'sh7fff, 64'hffff_ffff_ffff_ffff,
            1'b1, 16'sh7fff, SIG_TOP, 1'b1);
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b1, 1'b1, 16'sh3fff, 64'hffff_ffff_ffff_ffff,
            1'b1, 16'sh4000, SIG_TOP, 1'b1);
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b1, 1'b0, 16'sh3ffe, 64'hffff_ffff_ffff_ffff,
            1'b1, 16'sh3fff, SIG_TOP, 1'b0);
    // above the limit but no carry: no overflow
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b1, 1'b0, 16'sh4e20, SIG_TOP,
            1'b1, 16'sh4e20, SIG_TOP, 1'b0);
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b1, 1'b0, 16'sh0005, 64'h8000_0000_0000_0400,
            1'b0, '0, '0, 1'b0);
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b1, 1'b0, 16'sh0005, 64'h8000_0000_0000_0c00,
            1'b0, '0, '0, 1'b0);
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b1, 1'b1, 16'sh8000, 64'hffff_ffff_ffff_f801,
            1'b0, '0, '0, 1'b0);
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b1, 1'b0, 16'sh0001, 64'h8000_0000_0000_03ff,
            1'b0, '0, '0, 1'b0);
    add_row(RND_NEAREST, PREC_53, 16'sh4000, 1'b0, 1'b0, 16'sh7fff, 64'h0,
            1'b1, 16'sh7fff, 64'h0, 1'b0);
    add_row(RND_DOWN, PREC_24, 16'sh4000, 1'b1, 1'b1, 16'sh0000, 64'h8000_0000_0000_0001,
            1'b0, '0, '0, 1'b0);
    add_row(RND_DOWN, PREC_24, 16'sh4000, 1'b1, 1'b0, 16'sh0000, 64'h8000_0000_0000_0001,
            1'b0, '0, '0, 1'b0);
    add_row(RND_DOWN, PREC_24, 16'sh4000, 1'b1, 1'b1, 16'sh3fff, 64'hffff_ffff_ffff_ffff,
            1'b0, '0, '0, 1'b0);
    add_row(RND_UP, PREC_24, 16'sh4000, 1'b1, 1'b0, 16'sh0000, 64'h8000_0000_0000_0001,
            1'b0, '0, '0, 1'b0);
    add_row(RND_UP, PREC_24, 16'sh4000, 1'b1, 1'b1, 16'sh0000, 64'h8000_0000_0000_0001,
            1'b0, '0, '0, 1'b0);
    add_row(RND_UP, PREC_24, 16'sh4000, 1'b1, 1'b0, 16'sh0000, 64'h8000_0100_0000_0000,
            1'b0, '0, '0, 1'b0);
    add_row(RND_CHOP, PREC_24, 16'sh4000, 1'b1, 1'b0, 16'sh0007, 64'hffff_ffff_ffff_ffff,
            1'b1, 16'sh0007, 64'hffff_ff00_0000_0000, 1'b0);
    add_row(RND_NEAREST, PREC_24, 16'sh8000, 1'b1, 1'b0, 16'sh0064, 64'hffff_ffff_ffff_ffff,
            1'b1, 16'sh0065, SIG_TOP, 1'b1);
    add_row(RND_NEAREST, PREC_24, 16'sh8000, 1'b1, 1'b0, 16'sh0003, 64'h8000_0080_0000_0000,
            1'b0, '0, '0, 1'b0);
    add_row(RND_NEAREST, PREC_24, 16'sh8000, 1'b1, 1'b0, 16'sh0003, 64'h8000_0180_0000_0000,
            1'b0, '0, '0, 1'b0);
    add_row(RND_NEAREST, PREC_53, 16'sh7fff, 1'b1, 1'b0, 16'sh7ffe, 64'hffff_ffff_ffff_ffff,
            1'b1, 16'sh7fff, SIG_TOP, 1'b1);
    add_row(RND_NEAREST, PREC_53, 16'sh7fff, 1'b1, 1'b0, 16'sh7ffd, 64'hffff_ffff_ffff_ffff,
            1'b1, 16'sh7ffe, SIG_TOP, 1'b0);
    add_row(RND_UP, PREC_53, 16'sh7fff, 1'b1, 1'b0, 16'sh7fff, 64'hffff_ffff_ffff_ffff,
            1'b1, 16'sh7fff, SIG_TOP, 1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.mode != cur_mode || row.prec != cur_prec || row.limit != cur_limit) begin
        drain_results();
        write_cfg(row.mode, row.prec, row.limit);
      end
      send_item(row.value_valid, row.sign, row.exponent, row.significand, row.typed, row.want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      mode = x87pr_rmode_t'(ph % 4);
      case (ph % 3)
        0: limit = 16'($urandom);
        1: limit = (ph < 4) ? 16'sh8000 : 16'sh7fff;
        default: limit = OVF_LIMIT_RESET + 16'($urandom_range(0, 64)) - 16'sh0020;
      endcase
      write_cfg(mode, (ph >= 4) ? PREC_53 : PREC_24, limit);
      if (ph == PHASES - 1)
        idle_on = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off mid-phase until everything in flight has come out
        if (ph == 3 && i == PHASE_ITEMS / 2)
          drain_results();
        send_random();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (rounded_q.size() != 0) begin
      $error("%0d expected results never arrived", rounded_q.size());
      fails++;
    end
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
